// File: hdl/sgi_pkg.sv
// Shared constants for the segment intersection block: widths, register indexes, reset values.
package sgi_pkg;

    localparam int COORD_BITS_DEF = 24;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int TOL_W = 16;
    localparam int PAR_W = 32;
    localparam int PT_W  = 12;

    // t range test scale: 1.0 in Q1.16
    localparam int TSCALE_SHIFT = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PARAM_TOL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARALLEL_TOL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_TOL    = 2'd2;

    localparam logic [TOL_W-1:0] PARAM_TOL_RST    = 16'd66;
    localparam logic [PAR_W-1:0] PARALLEL_TOL_RST = 32'd17;
    localparam logic [PT_W-1:0]  POINT_TOL_RST    = 12'd0;

endpackage

// File: hdl/sgi_div_cell.sv
// One restoring-division cell: settles one quotient bit for the x and y lanes per cycle.
module sgi_div_cell #(
    parameter int RW    = 76,
    parameter int DENW  = 50,
    parameter int QB    = 26,
    parameter int SHIFT = 0,
    parameter int SW    = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          valid_in,
    input  logic [SW-1:0] side_in,
    input  logic [DENW-1:0] den_in,
    input  logic [RW-1:0] rem_x_in,
    input  logic [RW-1:0] rem_y_in,
    input  logic [QB-1:0] q_x_in,
    input  logic [QB-1:0] q_y_in,
    output logic          valid_out,
    output logic [SW-1:0] side_out,
    output logic [DENW-1:0] den_out,
    output logic [RW-1:0] rem_x_out,
    output logic [RW-1:0] rem_y_out,
    output logic [QB-1:0] q_x_out,
    output logic [QB-1:0] q_y_out
);

    logic          valid_reg;
    logic [SW-1:0] side_reg;
    logic [DENW-1:0] den_reg;
    logic [RW-1:0] rem_x_reg, rem_y_reg, rem_x_next, rem_y_next;
    logic [QB-1:0] q_x_reg, q_y_reg;
    logic [RW-1:0] trial;
    logic          ge_x, ge_y;

    always_comb
    begin
        trial      = RW'(den_in) << SHIFT;
        ge_x       = (rem_x_in >= trial);
        ge_y       = (rem_y_in >= trial);
        rem_x_next = ge_x ? (rem_x_in - trial) : rem_x_in;
        rem_y_next = ge_y ? (rem_y_in - trial) : rem_y_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg  <= side_in;
        den_reg   <= den_in;
        rem_x_reg <= rem_x_next;
        rem_y_reg <= rem_y_next;
        q_x_reg   <= {q_x_in[QB-2:0], ge_x};
        q_y_reg   <= {q_y_in[QB-2:0], ge_y};
    end

    assign valid_out = valid_reg;
    assign side_out  = side_reg;
    assign den_out   = den_reg;
    assign rem_x_out = rem_x_reg;
    assign rem_y_out = rem_y_reg;
    assign q_x_out   = q_x_reg;
    assign q_y_out   = q_y_reg;

endmodule

// File: hdl/segment_intersection_2d.sv
// Top level of the 2D segment intersection pipeline with its divider cell chain.
// The edge that takes start loads the first of seven front stages; COORD_BITS+2 divider
// cells and one output register follow, and done is driven from that output register.
// Throughput: one word per cycle; busy stays low, the pipeline never stalls.
// Every result shows on done/hit/cross_x/cross_y for one cycle and cannot be held off.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the tolerance defaults.
module segment_intersection_2d
    import sgi_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          func,
    input  logic signed [COORD_BITS-1:0]  a_start_x,
    input  logic signed [COORD_BITS-1:0]  a_start_y,
    input  logic signed [COORD_BITS-1:0]  a_end_x,
    input  logic signed [COORD_BITS-1:0]  a_end_y,
    input  logic signed [COORD_BITS-1:0]  b_start_x,
    input  logic signed [COORD_BITS-1:0]  b_start_y,
    input  logic signed [COORD_BITS-1:0]  b_end_x,
    input  logic signed [COORD_BITS-1:0]  b_end_y,
    input  logic                          cfg_we,
    input  logic [sgi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sgi_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                          done,
    output logic                          hit,
    output logic signed [COORD_BITS-1:0]  cross_x,
    output logic signed [COORD_BITS-1:0]  cross_y
);

    localparam int CB   = COORD_BITS;
    localparam int DW   = CB + 1;          // coordinate difference
    localparam int PRW  = 2 * DW;          // one product of differences
    localparam int PW   = PRW + 1;         // cross product
    localparam int DENW = PW - 1;          // |d|
    localparam int LO   = DW + 1;          // low slice of n1 for the split multiply
    localparam int HIW  = PW - LO;
    localparam int LPW  = LO + 1 + DW;
    localparam int HPW  = HIW + DW;
    localparam int NW   = PW + DW;         // n1 * delta
    localparam int QB   = CB + 2;          // quotient bits; |n1| < 2d keeps |q| below 2^(CB+1)
    localparam int RW   = DENW + QB;
    localparam int DTW  = DENW + TOL_W;
    localparam int TW   = PW + TSCALE_SHIFT + 2;
    localparam int PXW  = QB + 3;

    typedef struct packed {
        logic                 hit;
        logic                 match;
        logic signed [CB-1:0] mx;
        logic signed [CB-1:0] my;
        logic signed [CB-1:0] asx;
        logic signed [CB-1:0] asy;
        logic                 sx;
        logic                 sy;
    } side_t;

    localparam int SW = $bits(side_t);

    // ---------------- configuration registers ----------------
    logic [TOL_W-1:0] param_tol_reg;
    logic [PAR_W-1:0] par_tol_reg;
    logic [PT_W-1:0]  pt_tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            param_tol_reg <= PARAM_TOL_RST;
            par_tol_reg   <= PARALLEL_TOL_RST;
            pt_tol_reg    <= POINT_TOL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PARAM_TOL:    param_tol_reg <= cfg_data[TOL_W-1:0];
                REG_PARALLEL_TOL: par_tol_reg   <= cfg_data[PAR_W-1:0];
                REG_POINT_TOL:    pt_tol_reg    <= cfg_data[PT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Endpoints equal when each coordinate differs by at most the point tolerance.
    function automatic logic near_eq(input logic signed [CB-1:0] ax,
                                     input logic signed [CB-1:0] ay,
                                     input logic signed [CB-1:0] bx,
                                     input logic signed [CB-1:0] by,
                                     input logic [PT_W-1:0] tol);
        logic signed [DW-1:0] dx, dy;
        logic [DW-1:0]        mx, my;
        dx = DW'(ax) - DW'(bx);
        dy = DW'(ay) - DW'(by);
        mx = dx[DW-1] ? DW'(-dx) : DW'(dx);
        my = dy[DW-1] ? DW'(-dy) : DW'(dy);
        return ((DW+PT_W)'(mx) <= (DW+PT_W)'(tol)) && ((DW+PT_W)'(my) <= (DW+PT_W)'(tol));
    endfunction

    // t within [-tol, 1+tol]: n*2^16 + d*tol >= 0 and n*2^16 <= d*2^16 + d*tol
    function automatic logic t_ok(input logic signed [PW-1:0] n,
                                 input logic [DENW-1:0] den,
                                 input logic [DTW-1:0] dt);
        logic signed [TW-1:0] nt, dtw, dsh;
        nt  = TW'(n) <<< TSCALE_SHIFT;
        dtw = $signed(TW'(dt));
        dsh = $signed(TW'(den) << TSCALE_SHIFT);
        return ((nt + dtw) >= 0) && (nt <= (dsh + dtw));
    endfunction

    // ---------------- stage 1: capture the word ----------------
    logic                 s1_valid_reg, s1_func_reg;
    logic signed [CB-1:0] s1_asx_reg, s1_asy_reg, s1_aex_reg, s1_aey_reg;
    logic signed [CB-1:0] s1_bsx_reg, s1_bsy_reg, s1_bex_reg, s1_bey_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_func_reg <= func;
        s1_asx_reg  <= a_start_x;
        s1_asy_reg  <= a_start_y;
        s1_aex_reg  <= a_end_x;
        s1_aey_reg  <= a_end_y;
        s1_bsx_reg  <= b_start_x;
        s1_bsy_reg  <= b_start_y;
        s1_bex_reg  <= b_end_x;
        s1_bey_reg  <= b_end_y;
    end

    // ---------------- stage 2: differences and endpoint match ----------------
    logic                 s2_valid_reg, s2_match_reg;
    logic signed [CB-1:0] s2_mx_reg, s2_my_reg, s2_asx_reg, s2_asy_reg;
    logic signed [DW-1:0] s2_v1x_reg, s2_v1y_reg, s2_v2x_reg, s2_v2y_reg;
    logic signed [DW-1:0] s2_v3x_reg, s2_v3y_reg;
    logic                 ss, ee, se, es, m_start, m_end;

    always_comb
    begin
        ss      = near_eq(s1_asx_reg, s1_asy_reg, s1_bsx_reg, s1_bsy_reg, pt_tol_reg);
        ee      = near_eq(s1_aex_reg, s1_aey_reg, s1_bex_reg, s1_bey_reg, pt_tol_reg);
        se      = near_eq(s1_asx_reg, s1_asy_reg, s1_bex_reg, s1_bey_reg, pt_tol_reg);
        es      = near_eq(s1_aex_reg, s1_aey_reg, s1_bsx_reg, s1_bsy_reg, pt_tol_reg);
        m_start = (ss && !ee) || (se && !es);
        m_end   = (es && !se) || (ee && !ss);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_match_reg <= s1_func_reg && (m_start || m_end);
        s2_mx_reg    <= m_start ? s1_asx_reg : s1_aex_reg;
        s2_my_reg    <= m_start ? s1_asy_reg : s1_aey_reg;
        s2_asx_reg   <= s1_asx_reg;
        s2_asy_reg   <= s1_asy_reg;
        s2_v1x_reg   <= DW'(s1_aex_reg) - DW'(s1_asx_reg);
        s2_v1y_reg   <= DW'(s1_aey_reg) - DW'(s1_asy_reg);
        s2_v2x_reg   <= DW'(s1_bex_reg) - DW'(s1_bsx_reg);
        s2_v2y_reg   <= DW'(s1_bey_reg) - DW'(s1_bsy_reg);
        s2_v3x_reg   <= DW'(s1_bsx_reg) - DW'(s1_asx_reg);
        s2_v3y_reg   <= DW'(s1_bsy_reg) - DW'(s1_asy_reg);
    end

    // ---------------- stage 3: the six cross-product terms ----------------
    logic                  s3_valid_reg, s3_match_reg;
    logic signed [CB-1:0]  s3_mx_reg, s3_my_reg, s3_asx_reg, s3_asy_reg;
    logic signed [DW-1:0]  s3_v1x_reg, s3_v1y_reg;
    logic signed [PRW-1:0] s3_pa_reg, s3_pb_reg, s3_pc_reg, s3_pd_reg, s3_pe_reg, s3_pf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_match_reg <= s2_match_reg;
        s3_mx_reg    <= s2_mx_reg;
        s3_my_reg    <= s2_my_reg;
        s3_asx_reg   <= s2_asx_reg;
        s3_asy_reg   <= s2_asy_reg;
        s3_v1x_reg   <= s2_v1x_reg;
        s3_v1y_reg   <= s2_v1y_reg;
        s3_pa_reg    <= PRW'(s2_v1x_reg * s2_v2y_reg);
        s3_pb_reg    <= PRW'(s2_v1y_reg * s2_v2x_reg);
        s3_pc_reg    <= PRW'(s2_v3x_reg * s2_v2y_reg);
        s3_pd_reg    <= PRW'(s2_v3y_reg * s2_v2x_reg);
        s3_pe_reg    <= PRW'(s2_v3x_reg * s2_v1y_reg);
        s3_pf_reg    <= PRW'(s2_v3y_reg * s2_v1x_reg);
    end

    // ---------------- stage 4: d, n1, n2 ----------------
    logic                 s4_valid_reg, s4_match_reg;
    logic signed [CB-1:0] s4_mx_reg, s4_my_reg, s4_asx_reg, s4_asy_reg;
    logic signed [DW-1:0] s4_v1x_reg, s4_v1y_reg;
    logic signed [PW-1:0] s4_d_reg, s4_n1_reg, s4_n2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_match_reg <= s3_match_reg;
        s4_mx_reg    <= s3_mx_reg;
        s4_my_reg    <= s3_my_reg;
        s4_asx_reg   <= s3_asx_reg;
        s4_asy_reg   <= s3_asy_reg;
        s4_v1x_reg   <= s3_v1x_reg;
        s4_v1y_reg   <= s3_v1y_reg;
        s4_d_reg     <= PW'(s3_pa_reg) - PW'(s3_pb_reg);
        s4_n1_reg    <= PW'(s3_pc_reg) - PW'(s3_pd_reg);
        s4_n2_reg    <= PW'(s3_pe_reg) - PW'(s3_pf_reg);
    end

    // ---------------- stage 5: make d positive, parallel test ----------------
    logic                 s5_valid_reg, s5_match_reg, s5_nonpar_reg;
    logic signed [CB-1:0] s5_mx_reg, s5_my_reg, s5_asx_reg, s5_asy_reg;
    logic signed [DW-1:0] s5_v1x_reg, s5_v1y_reg;
    logic signed [PW-1:0] s5_n1_reg, s5_n2_reg;
    logic [DENW-1:0]      s5_den_reg;
    logic [PW-1:0]        d_abs;
    logic                 d_neg;

    always_comb
    begin
        d_neg = s4_d_reg[PW-1];
        d_abs = d_neg ? PW'(-s4_d_reg) : PW'(s4_d_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s5_match_reg  <= s4_match_reg;
        s5_mx_reg     <= s4_mx_reg;
        s5_my_reg     <= s4_my_reg;
        s5_asx_reg    <= s4_asx_reg;
        s5_asy_reg    <= s4_asy_reg;
        s5_v1x_reg    <= s4_v1x_reg;
        s5_v1y_reg    <= s4_v1y_reg;
        s5_nonpar_reg <= (PW+PAR_W)'(d_abs) > (PW+PAR_W)'(par_tol_reg);
        s5_den_reg    <= d_abs[DENW-1:0];
        s5_n1_reg     <= d_neg ? -s4_n1_reg : s4_n1_reg;
        s5_n2_reg     <= d_neg ? -s4_n2_reg : s4_n2_reg;
    end

    // ---------------- stage 6: tolerance product, split numerator products ----------------
    logic                  s6_valid_reg, s6_match_reg, s6_nonpar_reg;
    logic signed [CB-1:0]  s6_mx_reg, s6_my_reg, s6_asx_reg, s6_asy_reg;
    logic signed [PW-1:0]  s6_n1_reg, s6_n2_reg;
    logic [DENW-1:0]       s6_den_reg;
    logic [DTW-1:0]        s6_dt_reg;
    logic signed [LPW-1:0] s6_lx_reg, s6_ly_reg;
    logic signed [HPW-1:0] s6_hx_reg, s6_hy_reg;
    logic signed [LO:0]    n1_lo;
    logic signed [HIW-1:0] n1_hi;

    always_comb
    begin
        n1_lo = $signed({1'b0, s5_n1_reg[LO-1:0]});
        n1_hi = $signed(s5_n1_reg[PW-1:LO]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s6_match_reg  <= s5_match_reg;
        s6_nonpar_reg <= s5_nonpar_reg;
        s6_mx_reg     <= s5_mx_reg;
        s6_my_reg     <= s5_my_reg;
        s6_asx_reg    <= s5_asx_reg;
        s6_asy_reg    <= s5_asy_reg;
        s6_n1_reg     <= s5_n1_reg;
        s6_n2_reg     <= s5_n2_reg;
        s6_den_reg    <= s5_den_reg;
        s6_dt_reg     <= DTW'(s5_den_reg * param_tol_reg);
        s6_lx_reg     <= LPW'(n1_lo * s5_v1x_reg);
        s6_ly_reg     <= LPW'(n1_lo * s5_v1y_reg);
        s6_hx_reg     <= HPW'(n1_hi * s5_v1x_reg);
        s6_hy_reg     <= HPW'(n1_hi * s5_v1y_reg);
    end

    // ---------------- stage 7: range checks, numerator magnitude ----------------
    logic                 s7_valid_reg;
    side_t                s7_side_reg;
    logic [DENW-1:0]      s7_den_reg;
    logic [RW-1:0]        s7_rem_x_reg, s7_rem_y_reg;
    logic signed [NW-1:0] num_x, num_y;
    logic [NW-1:0]        mag_x, mag_y;
    side_t                side_next;

    always_comb
    begin
        num_x = (NW'(s6_hx_reg) <<< LO) + NW'(s6_lx_reg);
        num_y = (NW'(s6_hy_reg) <<< LO) + NW'(s6_ly_reg);
        mag_x = num_x[NW-1] ? NW'(-num_x) : NW'(num_x);
        mag_y = num_y[NW-1] ? NW'(-num_y) : NW'(num_y);
        side_next.hit   = s6_nonpar_reg && t_ok(s6_n1_reg, s6_den_reg, s6_dt_reg)
                          && t_ok(s6_n2_reg, s6_den_reg, s6_dt_reg);
        side_next.match = s6_match_reg;
        side_next.mx    = s6_mx_reg;
        side_next.my    = s6_my_reg;
        side_next.asx   = s6_asx_reg;
        side_next.asy   = s6_asy_reg;
        side_next.sx    = num_x[NW-1];
        side_next.sy    = num_y[NW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s7_side_reg  <= side_next;
        s7_den_reg   <= s6_den_reg;
        s7_rem_x_reg <= RW'(mag_x);
        s7_rem_y_reg <= RW'(mag_y);
    end

    // ---------------- divider chain: one quotient bit per cell, MSB first ----------------
    logic            ch_valid [0:QB];
    logic [SW-1:0]   ch_side  [0:QB];
    logic [DENW-1:0] ch_den   [0:QB];
    logic [RW-1:0]   ch_rem_x [0:QB];
    logic [RW-1:0]   ch_rem_y [0:QB];
    logic [QB-1:0]   ch_q_x   [0:QB];
    logic [QB-1:0]   ch_q_y   [0:QB];

    assign ch_valid[0] = s7_valid_reg;
    assign ch_side[0]  = s7_side_reg;
    assign ch_den[0]   = s7_den_reg;
    assign ch_rem_x[0] = s7_rem_x_reg;
    assign ch_rem_y[0] = s7_rem_y_reg;
    assign ch_q_x[0]   = '0;
    assign ch_q_y[0]   = '0;

    for (genvar g = 0; g < QB; g++)
    begin : g_cell
        sgi_div_cell #(
            .RW    (RW),
            .DENW  (DENW),
            .QB    (QB),
            .SHIFT (QB - 1 - g),
            .SW    (SW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (ch_valid[g]),
            .side_in   (ch_side[g]),
            .den_in    (ch_den[g]),
            .rem_x_in  (ch_rem_x[g]),
            .rem_y_in  (ch_rem_y[g]),
            .q_x_in    (ch_q_x[g]),
            .q_y_in    (ch_q_y[g]),
            .valid_out (ch_valid[g+1]),
            .side_out  (ch_side[g+1]),
            .den_out   (ch_den[g+1]),
            .rem_x_out (ch_rem_x[g+1]),
            .rem_y_out (ch_rem_y[g+1]),
            .q_x_out   (ch_q_x[g+1]),
            .q_y_out   (ch_q_y[g+1])
        );
    end

    // ---------------- output stage: round half away, offset, saturate ----------------
    side_t                 fin_side;
    logic [QB:0]           qm_x, qm_y;
    logic signed [PXW-1:0] px, py, sat_max, sat_min;
    logic signed [CB-1:0]  cx_next, cy_next;
    logic                  hit_next;

    logic                  done_reg, hit_reg;
    logic signed [CB-1:0]  cross_x_reg, cross_y_reg;

    always_comb
    begin
        fin_side = side_t'(ch_side[QB]);
        qm_x = (QB+1)'(ch_q_x[QB])
               + (QB+1)'({ch_rem_x[QB], 1'b0} >= (RW+1)'(ch_den[QB]));
        qm_y = (QB+1)'(ch_q_y[QB])
               + (QB+1)'({ch_rem_y[QB], 1'b0} >= (RW+1)'(ch_den[QB]));
        px = PXW'(fin_side.asx)
             + (fin_side.sx ? -$signed(PXW'(qm_x)) : $signed(PXW'(qm_x)));
        py = PXW'(fin_side.asy)
             + (fin_side.sy ? -$signed(PXW'(qm_y)) : $signed(PXW'(qm_y)));
        sat_max = $signed({{(PXW-CB+1){1'b0}}, {(CB-1){1'b1}}});
        sat_min = ~sat_max;
        hit_next = fin_side.match || fin_side.hit;
        if (fin_side.match)
        begin
            cx_next = fin_side.mx;
            cy_next = fin_side.my;
        end
        else if (fin_side.hit)
        begin
            cx_next = (px > sat_max) ? CB'(sat_max) : ((px < sat_min) ? CB'(sat_min) : CB'(px));
            cy_next = (py > sat_max) ? CB'(sat_max) : ((py < sat_min) ? CB'(sat_min) : CB'(py));
        end
        else
        begin
            cx_next = '0;
            cy_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ch_valid[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg     <= hit_next;
        cross_x_reg <= cx_next;
        cross_y_reg <= cy_next;
    end

    assign done    = done_reg;
    assign hit     = hit_reg;
    assign cross_x = cross_x_reg;
    assign cross_y = cross_y_reg;

endmodule

// File: tb/sv/segment_intersection_2d_checker.sv
// Checker for the segment intersection block: predicts each result word and compares it.
`timescale 1ns / 100ps

module segment_intersection_2d_checker
    import sgi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic                    func,
    input  logic signed [23:0]      a_start_x,
    input  logic signed [23:0]      a_start_y,
    input  logic signed [23:0]      a_end_x,
    input  logic signed [23:0]      a_end_y,
    input  logic signed [23:0]      b_start_x,
    input  logic signed [23:0]      b_start_y,
    input  logic signed [23:0]      b_end_x,
    input  logic signed [23:0]      b_end_y,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    done,
    input  logic                    hit,
    input  logic signed [23:0]      cross_x,
    input  logic signed [23:0]      cross_y,
    output int                      errors,
    output int                      pending
);

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic              hit;
        logic signed [23:0] x;
        logic signed [23:0] y;
    } crossing_t;

    crossing_t         crossings_due[$];
    logic [TOL_W-1:0]  t_slack;
    logic [PAR_W-1:0]  par_limit;
    logic [PT_W-1:0]   pt_limit;

    assign pending = crossings_due.size();

    initial errors = 0;

    task automatic report(input string what);
        $display("%0t mismatch: %s", $time, what);
        errors++;
    endtask

    function automatic logic near(input longint ax, input longint ay,
                                  input longint bx, input longint by);
        longint dx;
        longint dy;
        dx = ax - bx;
        dy = ay - by;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return dx <= longint'(pt_limit) && dy <= longint'(pt_limit);
    endfunction

    // t inside [-slack, 1+slack] without division, d already positive
    function automatic logic t_in_range(input wide_t n, input wide_t d);
        wide_t nt;
        nt = n * 65536;
        if (nt + d * wide_t'(t_slack) < 0) return 1'b0;
        return nt <= d * (65536 + wide_t'(t_slack));
    endfunction

    // quotient rounded to nearest, ties away from zero, magnitude capped at 2^40
    function automatic longint round_div(input wide_t num, input wide_t d);
        wide_t mag;
        wide_t q;
        wide_t r;
        mag = (num < 0) ? -num : num;
        q = mag / d;
        r = mag % d;
        if (2 * r >= d) q = q + 1;
        if (q > (wide_t'(1) <<< 40)) q = wide_t'(1) <<< 40;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [23:0] clamp(input longint v);
        if (v > 64'sd8388607) return 24'sh7fffff;
        if (v < -64'sd8388608) return 24'sh800000;
        return v[23:0];
    endfunction

    function automatic crossing_t predict_crossing(input logic f,
        input longint asx, input longint asy, input longint aex, input longint aey,
        input longint bsx, input longint bsy, input longint bex, input longint bey);
        crossing_t res;
        logic ss, ee, se, es, settled;
        longint px, py;
        wide_t v1x, v1y, v2x, v2y, v3x, v3y, d, n1, n2;
        res = '0;
        settled = 1'b0;
        px = 0;
        py = 0;
        if (f) begin
            ss = near(asx, asy, bsx, bsy);
            ee = near(aex, aey, bex, bey);
            se = near(asx, asy, bex, bey);
            es = near(aex, aey, bsx, bsy);
            if ((ss && !ee) || (se && !es)) begin
                res.hit = 1'b1; px = asx; py = asy; settled = 1'b1;
            end else if ((es && !se) || (ee && !ss)) begin
                res.hit = 1'b1; px = aex; py = aey; settled = 1'b1;
            end
        end
        if (!settled) begin
            v1x = aex - asx; v1y = aey - asy;
            v2x = bex - bsx; v2y = bey - bsy;
            v3x = bsx - asx; v3y = bsy - asy;
            d  = v1x * v2y - v1y * v2x;
            n1 = v3x * v2y - v3y * v2x;
            n2 = v3x * v1y - v3y * v1x;
            if (((d < 0) ? -d : d) > wide_t'(par_limit)) begin
                if (d < 0) begin
                    d = -d; n1 = -n1; n2 = -n2;
                end
                if (t_in_range(n1, d) && t_in_range(n2, d)) begin
                    res.hit = 1'b1;
                    px = asx + round_div(n1 * v1x, d);
                    py = asy + round_div(n1 * v1y, d);
                end
            end
        end
        if (res.hit) begin
            res.x = clamp(px);
            res.y = clamp(py);
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        crossing_t want;
        if (!rst_n) begin
            t_slack   <= PARAM_TOL_RST;
            par_limit <= PARALLEL_TOL_RST;
            pt_limit  <= POINT_TOL_RST;
        end else begin
            if (start && !busy)
                crossings_due.push_back(predict_crossing(func,
                    a_start_x, a_start_y, a_end_x, a_end_y,
                    b_start_x, b_start_y, b_end_x, b_end_y));
            if (done) begin
                if (crossings_due.size() == 0) begin
                    report("result word with nothing expected");
                end else begin
                    want = crossings_due.pop_front();
                    if (hit !== want.hit || cross_x !== want.x || cross_y !== want.y)
                        report($sformatf("got hit %b (%0d,%0d) want hit %b (%0d,%0d)",
                            hit, cross_x, cross_y, want.hit, want.x, want.y));
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_PARAM_TOL:    t_slack   <= cfg_data[TOL_W-1:0];
                    REG_PARALLEL_TOL: par_limit <= cfg_data[PAR_W-1:0];
                    REG_POINT_TOL:    pt_limit  <= cfg_data[PT_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

endmodule

// File: tb/sv/segment_intersection_2d_tb.sv
// Testbench top for the segment intersection block: stimulus, tolerance phases and verdict.
`timescale 1ns / 100ps

module segment_intersection_2d_tb;
    import sgi_pkg::*;

    localparam int LATENCY     = 33;   // delay from start to done, in clock edges
    localparam int STALL_LIMIT = 4000; // idle cycles before the watchdog trips
    localparam int MAX_C       = 8388607;
    localparam int MIN_C       = -8388608;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic                   func;
    logic signed [23:0]     crd [8];   // a_s x/y, a_e x/y, b_s x/y, b_e x/y
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   done;
    logic                   hit;
    logic signed [23:0]     cross_x;
    logic signed [23:0]     cross_y;
    int                     errors;
    int                     pending;
    int                     quiet_cycles;

    segment_intersection_2d dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .a_start_x(crd[0]), .a_start_y(crd[1]), .a_end_x(crd[2]), .a_end_y(crd[3]),
        .b_start_x(crd[4]), .b_start_y(crd[5]), .b_end_x(crd[6]), .b_end_y(crd[7]),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .hit(hit), .cross_x(cross_x), .cross_y(cross_y)
    );

    segment_intersection_2d_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .a_start_x(crd[0]), .a_start_y(crd[1]), .a_end_x(crd[2]), .a_end_y(crd[3]),
        .b_start_x(crd[4]), .b_start_y(crd[5]), .b_end_x(crd[6]), .b_end_y(crd[7]),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .hit(hit), .cross_x(cross_x), .cross_y(cross_y),
        .errors(errors), .pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: trip when neither an input word nor a result word moves for too long.
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Signed value in [-mag, mag].
    function automatic int spread(input int mag);
        return int'($urandom_range(2 * mag)) - mag;
    endfunction

    // Send one word: hold start low for a random gap, then present it until taken.
    task automatic send_word(input logic f, input int c [8]);
        int gap;
        gap = $urandom_range(3) == 0 ? 0 : $urandom_range(13);
        if ($urandom_range(4) == 0) gap = 0;   // stretches of back-to-back words
        repeat (gap) begin
            start = 1'b0;
            @(negedge clk);
        end
        func = f;
        foreach (c[i]) crd[i] = 24'(c[i]);
        start = 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    // Drain all pending words, then let the pipeline settle before touching registers.
    task automatic settle();
        start = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic set_tolerances(input logic [31:0] t, input logic [31:0] p,
                                  input logic [31:0] q);
        settle();
        write_reg(REG_PARAM_TOL, t);
        write_reg(REG_PARALLEL_TOL, p);
        write_reg(REG_POINT_TOL, q);
        // the index past the last register is unused; the block must ignore it
        write_reg(CFG_IDX_W'(REG_POINT_TOL + 1), $urandom);
    endtask

    // Random pair shaped by kind: crossing, shared endpoint, parallel, touching, raw noise.
    task automatic random_word();
        int c [8];
        int px, py, k, j;
        logic f;
        f = $urandom_range(1);
        k = $urandom_range(9);
        px = spread(1 << 21);
        py = spread(1 << 21);
        case (k)
            0, 1, 2, 3: begin
                // both segments run through (px,py)
                c[0] = px - spread(1 << 21); c[1] = py - spread(1 << 21);
                c[2] = 2 * px - c[0] + spread(8); c[3] = 2 * py - c[1] + spread(8);
                c[4] = px - spread(1 << 21); c[5] = py - spread(1 << 21);
                c[6] = 2 * px - c[4] + spread(8); c[7] = 2 * py - c[5] + spread(8);
                if ($urandom_range(3) == 0)
                    for (j = 0; j < 8; j++) c[j] = c[j] >>> $urandom_range(16);
            end
            4, 5: begin
                // shared or nearly shared endpoint, often in endpoint-match mode
                for (j = 0; j < 8; j++) c[j] = spread(1 << 22);
                j = $urandom_range(3);
                c[4 + 2 * (j & 1)]     = c[2 * (j >> 1)]     + spread(4);
                c[4 + 2 * (j & 1) + 1] = c[2 * (j >> 1) + 1] + spread(4);
                if ($urandom_range(3) == 0) begin
                    c[6 - 2 * (j & 1)]     = c[2 - 2 * (j >> 1)]     + spread(4);
                    c[6 - 2 * (j & 1) + 1] = c[2 - 2 * (j >> 1) + 1] + spread(4);
                end
                if ($urandom_range(2) != 0) f = 1'b1;
            end
            6: begin
                // parallel or collinear, with a slight skew now and then
                c[0] = px; c[1] = py;
                c[2] = px + spread(1 << 20); c[3] = py + spread(1 << 20);
                j = spread(1 << 20);
                c[4] = c[0] + j; c[5] = c[1] + ($urandom_range(1) ? j : 0);
                c[6] = c[2] + j + spread(1); c[7] = c[3] + ($urandom_range(1) ? j : 0);
            end
            7: begin
                // B starts near A's end: t1 around 1, t2 around 0
                for (j = 0; j < 4; j++) c[j] = spread(1 << 20);
                c[4] = c[2] + spread(64); c[5] = c[3] + spread(64);
                c[6] = spread(1 << 22); c[7] = spread(1 << 22);
            end
            default: begin
                for (j = 0; j < 8; j++) c[j] = int'($urandom_range(MAX_C - MIN_C)) + MIN_C;
            end
        endcase
        send_word(f, c);
    endtask

    task automatic directed_words();
        int c [8];
        // plain cross at the origin
        c = '{-4096, 0, 4096, 0, 0, -4096, 0, 4096};       send_word(1'b0, c);
        // extremes of the range, diagonals crossing near zero
        c = '{MIN_C, MIN_C, MAX_C, MAX_C, MIN_C, MAX_C, MAX_C, MIN_C};
        send_word(1'b0, c);
        send_word(1'b1, c);
        // all corners on one side: far-out crossing gets saturated only if in range
        c = '{MAX_C, MAX_C, MAX_C, MIN_C, MIN_C, MAX_C, MAX_C, MAX_C};
        send_word(1'b0, c);
        // identical segments: parallel, no hit in plain mode
        c = '{100, 200, 5000, 9000, 100, 200, 5000, 9000};   send_word(1'b0, c);
        send_word(1'b1, c);
        // degenerate segments (points)
        c = '{7, 7, 7, 7, 7, 7, 7, 7};                       send_word(1'b0, c);
        send_word(1'b1, c);
        // shared start, shared end, start-end and end-start in match mode
        c = '{0, 0, 4096, 0, 0, 0, 0, 4096};                 send_word(1'b1, c);
        c = '{4096, 0, 0, 0, 0, 4096, 0, 0};                 send_word(1'b1, c);
        c = '{0, 0, 4096, 4096, -4096, 4096, 0, 0};          send_word(1'b1, c);
        c = '{-4096, 0, 0, 0, 0, 0, 4096, 4096};             send_word(1'b1, c);
        // reversed segment: start-end and end-start both hold
        c = '{0, 0, 4096, 4096, 4096, 4096, 0, 0};           send_word(1'b1, c);
        // parallel offset lines
        c = '{0, 0, 8192, 8192, 0, 10, 8192, 8202};          send_word(1'b0, c);
        // touching at t just beyond 1 and just below 0
        c = '{0, 0, 4096, 0, 4097, -100, 4097, 100};         send_word(1'b0, c);
        c = '{0, 0, 4096, 0, -1, -100, -1, 100};             send_word(1'b0, c);
        // ties in rounding: odd spans
        c = '{0, 0, 3, 1, 1, -1, 1, 2};                      send_word(1'b0, c);
        c = '{0, 0, -3, -1, -1, 1, -1, -2};                  send_word(1'b0, c);
        // all-ones and sign bit patterns
        c = '{-1, -1, 0, 0, MIN_C, 0, MAX_C, 0};             send_word(1'b1, c);
        c = '{MAX_C, 0, MIN_C, 0, 0, MAX_C, 0, MIN_C};       send_word(1'b0, c);
    endtask

    initial begin
        rst_n     = 1'b0;
        start     = 1'b0;
        func      = 1'b0;
        foreach (crd[i]) crd[i] = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset tolerances first
        directed_words();
        repeat (80) random_word();

        // everything tight: zero slack, exact parallel only, exact point match
        set_tolerances(32'd0, 32'd0, 32'd0);
        directed_words();
        repeat (80) random_word();

        // everything at its widest
        set_tolerances(32'hffff, 32'hffff_ffff, 32'hfff);
        directed_words();
        repeat (80) random_word();

        // two random settings to finish
        repeat (2) begin
            set_tolerances($urandom, $urandom >> $urandom_range(31),
                           $urandom_range(64));
            repeat (80) random_word();
        end

        settle();
        repeat (LATENCY) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
